// ===== rtl/fsot_pkg.sv =====
// Shared types, codes and constants for the frame slot ownership tracker.
package fsot_pkg;

    localparam int MAX_SLOTS  = 8;
    localparam int SLOT_AW    = $clog2(MAX_SLOTS);
    localparam int ACTIVE_W   = 4;
    localparam int FREE_W     = $clog2(MAX_SLOTS + 1);
    localparam int TAG_W      = 32;
    localparam int FENCE_W    = 64;
    localparam int CNT_W      = 32;
    localparam int REC_W      = TAG_W + 4 * FENCE_W;

    localparam logic [ACTIVE_W-1:0] ACTIVE_MAX = ACTIVE_W'(MAX_SLOTS);
    localparam logic [ACTIVE_W-1:0] ACTIVE_MIN = ACTIVE_W'(1);

    // slot phase shown when the addressed slot does not exist
    localparam logic [2:0] PHASE_NO_SLOT = 3'd7;

    typedef enum logic [2:0] {
        PH_FREE           = 3'd0,
        PH_COPYING        = 3'd1,
        PH_READY_WORKER   = 3'd2,
        PH_WORKER_RUN     = 3'd3,
        PH_READY_PRODUCER = 3'd4,
        PH_COPYBACK       = 3'd5
    } phase_t;

    typedef enum logic [2:0] {
        OP_BEGIN_COPY     = 3'd0,
        OP_COPY_DONE      = 3'd1,
        OP_WORKER_BEGIN   = 3'd2,
        OP_WORKER_DONE    = 3'd3,
        OP_BEGIN_COPYBACK = 3'd4,
        OP_RELEASE        = 3'd5
    } op_t;

    typedef enum logic [2:0] {
        ERR_NONE   = 3'd0,
        ERR_SLOT   = 3'd1,
        ERR_PHASE  = 3'd2,
        ERR_GAME   = 3'd3,
        ERR_WORKER = 3'd4
    } err_t;

    // per-slot record held in the slot memory
    typedef struct packed {
        logic [TAG_W-1:0]   tag;
        logic [FENCE_W-1:0] game_need;
        logic [FENCE_W-1:0] game_seen;
        logic [FENCE_W-1:0] worker_need;
        logic [FENCE_W-1:0] worker_seen;
    } slot_rec_t;

    // decision of the event unit for one beat
    typedef struct packed {
        err_t      err;
        logic      phase_we;
        phase_t    phase_new;
        logic      rec_we;
        slot_rec_t rec_new;
        logic      started_inc;
        logic      completed_inc;
    } ev_result_t;

endpackage

// ===== rtl/fsot_slot_ram.sv =====
// Generic single-write, single-read synchronous RAM with per-entry valid bits.
module fsot_slot_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [DEPTH-1:0] valid_reg;
    logic [WIDTH-1:0] rdata_reg;
    logic             rvalid_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            rvalid_reg <= 1'b0;
        end
        else
        begin
            if (we)
            begin
                valid_reg[waddr] <= 1'b1;
            end
            if (re)
            begin
                rvalid_reg <= valid_reg[raddr];
            end
        end
    end

    // unwritten entries read as zero
    assign rdata = rvalid_reg ? rdata_reg : {WIDTH{1'b0}};

endmodule

// ===== rtl/fsot_event_unit.sv =====
// Phase check and record update for one event.
module fsot_event_unit (
    input  logic [2:0]                      op,
    input  logic [3:0]                      slot_index,
    input  logic [fsot_pkg::TAG_W-1:0]      frame_tag,
    input  logic [fsot_pkg::FENCE_W-1:0]    game_fv,
    input  logic [fsot_pkg::FENCE_W-1:0]    worker_fv,
    input  logic [fsot_pkg::ACTIVE_W-1:0]   active_slots,
    input  fsot_pkg::phase_t                cur_phase,
    input  fsot_pkg::slot_rec_t             cur_rec,
    output fsot_pkg::ev_result_t            res
);
    import fsot_pkg::*;

    logic [FENCE_W-1:0] game_max;
    logic [FENCE_W-1:0] worker_max;

    assign game_max   = (game_fv > cur_rec.game_seen) ? game_fv : cur_rec.game_seen;
    assign worker_max = (worker_fv > cur_rec.worker_seen) ? worker_fv
                                                          : cur_rec.worker_seen;

    always_comb
    begin
        res               = '0;
        res.err           = ERR_NONE;
        res.phase_new     = cur_phase;
        res.rec_new       = cur_rec;
        if (slot_index >= active_slots)
        begin
            res.err = ERR_SLOT;
        end
        else
        begin
            unique case (op_t'(op))
                OP_BEGIN_COPY:
                begin
                    if (cur_phase != PH_FREE)
                    begin
                        res.err = ERR_PHASE;
                    end
                    else
                    begin
                        res.phase_we          = 1'b1;
                        res.phase_new         = PH_COPYING;
                        res.rec_we            = 1'b1;
                        res.rec_new.tag       = frame_tag;
                        res.rec_new.game_need = game_fv;
                        res.started_inc       = 1'b1;
                    end
                end
                OP_COPY_DONE:
                begin
                    if (cur_phase != PH_COPYING)
                    begin
                        res.err = ERR_PHASE;
                    end
                    else
                    begin
                        res.phase_we          = 1'b1;
                        res.phase_new         = PH_READY_WORKER;
                        res.rec_we            = 1'b1;
                        res.rec_new.game_seen = game_fv;
                    end
                end
                OP_WORKER_BEGIN:
                begin
                    if (cur_phase != PH_READY_WORKER)
                    begin
                        res.err = ERR_PHASE;
                    end
                    else
                    begin
                        res.phase_we            = 1'b1;
                        res.phase_new           = PH_WORKER_RUN;
                        res.rec_we              = 1'b1;
                        res.rec_new.worker_need = worker_fv;
                    end
                end
                OP_WORKER_DONE:
                begin
                    if (cur_phase != PH_WORKER_RUN)
                    begin
                        res.err = ERR_PHASE;
                    end
                    else
                    begin
                        res.phase_we            = 1'b1;
                        res.phase_new           = PH_READY_PRODUCER;
                        res.rec_we              = 1'b1;
                        res.rec_new.worker_seen = worker_fv;
                    end
                end
                OP_BEGIN_COPYBACK:
                begin
                    if (cur_phase != PH_READY_PRODUCER)
                    begin
                        res.err = ERR_PHASE;
                    end
                    else
                    begin
                        res.phase_we  = 1'b1;
                        res.phase_new = PH_COPYBACK;
                    end
                end
                OP_RELEASE:
                begin
                    if (cur_phase != PH_COPYBACK)
                    begin
                        res.err = ERR_PHASE;
                    end
                    else
                    begin
                        // fence maxima are kept even on refusal
                        res.rec_we              = 1'b1;
                        res.rec_new.game_seen   = game_max;
                        res.rec_new.worker_seen = worker_max;
                        if (game_max < cur_rec.game_need)
                        begin
                            res.err = ERR_GAME;
                        end
                        else if (worker_max < cur_rec.worker_need)
                        begin
                            res.err = ERR_WORKER;
                        end
                        else
                        begin
                            res.phase_we      = 1'b1;
                            res.phase_new     = PH_FREE;
                            res.completed_inc = 1'b1;
                        end
                    end
                end
                default:
                begin
                    res.err = ERR_PHASE;
                end
            endcase
        end
    end

endmodule

// ===== rtl/fsot_free_scan.sv =====
// Free slot count and lowest free slot over the active slots.
module fsot_free_scan (
    input  fsot_pkg::phase_t                phases [fsot_pkg::MAX_SLOTS],
    input  logic [fsot_pkg::ACTIVE_W-1:0]   active_slots,
    output logic [fsot_pkg::FREE_W-1:0]     free_cnt,
    output logic                            any_free,
    output logic [fsot_pkg::SLOT_AW-1:0]    first_free
);
    import fsot_pkg::*;

    always_comb
    begin
        free_cnt   = '0;
        any_free   = 1'b0;
        first_free = '0;
        for (int i = 0; i < MAX_SLOTS; i++)
        begin
            if ((ACTIVE_W'(i) < active_slots) && (phases[i] == PH_FREE))
            begin
                if (!any_free)
                begin
                    first_free = SLOT_AW'(i);
                end
                any_free = 1'b1;
                free_cnt = free_cnt + FREE_W'(1);
            end
        end
    end

endmodule

// ===== rtl/frame_slot_ownership_tracker.sv =====
// Top level: frame slot ownership tracker with memory-held slot records.
// Flow: an accepted beat is latched and its slot record is read from the RAM;
//   in the execute state the record is checked and written back, and the
//   result goes to the output register. One event is handled at a time, one
//   record read and write per event; a stalled output holds the event in its execute state.
// Reset (rst_n low, async): all slots free, records read as zero through the
//   RAM valid bits, counters zero, active_slots 8; no clearing pass needed.
module frame_slot_ownership_tracker (
    input  logic                            clk,
    input  logic                            rst_n,
    // configuration
    input  logic                            cfg_we,
    input  logic [fsot_pkg::ACTIVE_W-1:0]   cfg_wdata,
    // input event channel
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [2:0]                      op,
    input  logic [3:0]                      slot_index,
    input  logic [fsot_pkg::TAG_W-1:0]      frame_tag,
    input  logic [fsot_pkg::FENCE_W-1:0]    game_fence_value,
    input  logic [fsot_pkg::FENCE_W-1:0]    worker_fence_value,
    // result channel
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic                            accepted,
    output logic [2:0]                      error_code,
    output logic [2:0]                      slot_phase_after,
    output logic [fsot_pkg::TAG_W-1:0]      slot_frame_tag,
    output logic [fsot_pkg::FREE_W-1:0]     free_slots,
    output logic                            any_free,
    output logic [fsot_pkg::SLOT_AW-1:0]    first_free,
    output logic [fsot_pkg::CNT_W-1:0]      refusal_total,
    output logic [fsot_pkg::CNT_W-1:0]      started_total,
    output logic [fsot_pkg::CNT_W-1:0]      completed_total
);
    import fsot_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,   // waiting for an event beat; RAM read issued on accept
        ST_EXEC = 2'b10    // record available; decide, write back, post result
    } state_t;

    state_t state_reg, state_next;

    // latched event
    logic [2:0]         op_reg;
    logic [3:0]         idx_reg;
    logic [TAG_W-1:0]   tag_reg;
    logic [FENCE_W-1:0] gf_reg;
    logic [FENCE_W-1:0] wf_reg;

    logic [ACTIVE_W-1:0] active_reg, active_next;

    // phases live in flops: every one is needed each cycle for the free scan
    phase_t phase_reg  [MAX_SLOTS];
    phase_t phase_next [MAX_SLOTS];

    logic [CNT_W-1:0] refusal_reg, refusal_next;
    logic [CNT_W-1:0] started_reg, started_next;
    logic [CNT_W-1:0] completed_reg, completed_next;

    // output register
    logic               out_valid_reg;
    logic               accepted_reg;
    logic [2:0]         err_reg;
    logic [2:0]         phase_out_reg;
    logic [TAG_W-1:0]   tag_out_reg;
    logic [FREE_W-1:0]  free_reg;
    logic               any_free_reg;
    logic [SLOT_AW-1:0] first_free_reg;

    logic                in_fire;
    logic                exec_fire;
    logic [SLOT_AW-1:0]  slot_addr;
    slot_rec_t           rd_rec;
    slot_rec_t           rd_rec_q;
    phase_t              cur_phase;
    ev_result_t          ev;
    logic [FREE_W-1:0]   scan_count;
    logic                scan_any;
    logic [SLOT_AW-1:0]  scan_first;
    logic                refused;

    // one event in flight at a time; the FSM is the interlock on the RAM
    assign in_stall  = (state_reg != ST_IDLE);
    assign in_fire   = in_valid && !in_stall;
    // result may land when the output register is empty or draining now
    assign exec_fire = (state_reg == ST_EXEC) && !(out_valid_reg && out_stall);
    assign slot_addr = idx_reg[SLOT_AW-1:0];

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (exec_fire)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    fsot_slot_ram #(
        .WIDTH (REC_W),
        .DEPTH (MAX_SLOTS)
    ) u_slot_ram (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (exec_fire && ev.rec_we),
        .waddr (slot_addr),
        .wdata (ev.rec_new),
        .re    (in_fire),
        .raddr (slot_index[SLOT_AW-1:0]),
        .rdata (rd_rec_q)
    );

    assign rd_rec    = rd_rec_q;
    assign cur_phase = phase_reg[slot_addr];

    fsot_event_unit u_event (
        .op           (op_reg),
        .slot_index   (idx_reg),
        .frame_tag    (tag_reg),
        .game_fv      (gf_reg),
        .worker_fv    (wf_reg),
        .active_slots (active_reg),
        .cur_phase    (cur_phase),
        .cur_rec      (rd_rec),
        .res          (ev)
    );

    // phase vector after this event, used both for the update and the scan
    always_comb
    begin
        for (int i = 0; i < MAX_SLOTS; i++)
        begin
            phase_next[i] = phase_reg[i];
        end
        if (ev.phase_we)
        begin
            phase_next[slot_addr] = ev.phase_new;
        end
    end

    fsot_free_scan u_scan (
        .phases       (phase_next),
        .active_slots (active_reg),
        .free_cnt     (scan_count),
        .any_free     (scan_any),
        .first_free   (scan_first)
    );

    assign refused        = (ev.err != ERR_NONE);
    assign refusal_next   = refusal_reg + CNT_W'(refused);
    assign started_next   = started_reg + CNT_W'(ev.started_inc);
    assign completed_next = completed_reg + CNT_W'(ev.completed_inc);

    // writes saturate into 1..MAX_SLOTS
    always_comb
    begin
        if (cfg_wdata < ACTIVE_MIN)
        begin
            active_next = ACTIVE_MIN;
        end
        else if (cfg_wdata > ACTIVE_MAX)
        begin
            active_next = ACTIVE_MAX;
        end
        else
        begin
            active_next = cfg_wdata;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            active_reg    <= ACTIVE_MAX;
            refusal_reg   <= '0;
            started_reg   <= '0;
            completed_reg <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < MAX_SLOTS; i++)
            begin
                phase_reg[i] <= PH_FREE;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                active_reg <= active_next;
            end
            if (exec_fire)
            begin
                out_valid_reg <= 1'b1;
                refusal_reg   <= refusal_next;
                started_reg   <= started_next;
                completed_reg <= completed_next;
                for (int i = 0; i < MAX_SLOTS; i++)
                begin
                    phase_reg[i] <= phase_next[i];
                end
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload: event latch and result beat
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            op_reg  <= op;
            idx_reg <= slot_index;
            tag_reg <= frame_tag;
            gf_reg  <= game_fence_value;
            wf_reg  <= worker_fence_value;
        end
        if (exec_fire)
        begin
            accepted_reg   <= !refused;
            err_reg        <= ev.err;
            phase_out_reg  <= (ev.err == ERR_SLOT) ? PHASE_NO_SLOT : ev.phase_new;
            tag_out_reg    <= (ev.err == ERR_SLOT) ? '0 : ev.rec_new.tag;
            free_reg       <= scan_count;
            any_free_reg   <= scan_any;
            first_free_reg <= scan_first;
        end
    end

    assign out_valid        = out_valid_reg;
    assign accepted         = accepted_reg;
    assign error_code       = err_reg;
    assign slot_phase_after = phase_out_reg;
    assign slot_frame_tag   = tag_out_reg;
    assign free_slots       = free_reg;
    assign any_free         = any_free_reg;
    assign first_free       = first_free_reg;
    assign refusal_total    = refusal_reg;
    assign started_total    = started_reg;
    assign completed_total  = completed_reg;

    // checks
    a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg))
        else $error("state register not one-hot");

    a_accept_err: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (accepted == (error_code == ERR_NONE)))
        else $error("accepted flag disagrees with error code");

    a_free_any: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (any_free == (free_slots != '0)))
        else $error("any_free disagrees with free count");

    a_refusal_step: assert property (@(posedge clk) disable iff (!rst_n)
        exec_fire && refused |=> (refusal_total == $past(refusal_total) + CNT_W'(1)))
        else $error("refusal counter did not advance on a refused event");

endmodule
